FILE: rtl/core/enig_pkg.sv
// Shared types, rotor wiring tables and modular helpers for the rotor cipher.
`timescale 1ns / 1ps
`default_nettype none

package enig_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ALPHA = 26;
  localparam int unsigned NUM_PASS = 7;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [LETTER_W:0] letter_ext_t;
  typedef letter_t wiring_t [ALPHA];

  localparam letter_ext_t ALPHA_X = 6'd26;
  localparam letter_ext_t RIGHT_STEP_X = 6'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_START = 2'd2;

  localparam logic [2:0] PASS_BETA_FWD = 3'd0;
  localparam logic [2:0] PASS_III_FWD = 3'd1;
  localparam logic [2:0] PASS_GAMMA_FWD = 3'd2;
  localparam logic [2:0] PASS_REFL = 3'd3;
  localparam logic [2:0] PASS_GAMMA_BWD = 3'd4;
  localparam logic [2:0] PASS_III_BWD = 3'd5;
  localparam logic [2:0] PASS_BETA_BWD = 3'd6;

  localparam wiring_t BETA_FWD = '{
    5'd11, 5'd4, 5'd24, 5'd9, 5'd21, 5'd2, 5'd13, 5'd8, 5'd23, 5'd22, 5'd15, 5'd1, 5'd16,
    5'd12, 5'd3, 5'd17, 5'd19, 5'd0, 5'd10, 5'd25, 5'd6, 5'd5, 5'd20, 5'd7, 5'd14, 5'd18};
  localparam wiring_t BETA_BWD = '{
    5'd17, 5'd11, 5'd5, 5'd14, 5'd1, 5'd21, 5'd20, 5'd23, 5'd7, 5'd3, 5'd18, 5'd0, 5'd13,
    5'd6, 5'd24, 5'd10, 5'd12, 5'd15, 5'd25, 5'd16, 5'd22, 5'd4, 5'd9, 5'd8, 5'd2, 5'd19};
  localparam wiring_t III_FWD = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
  localparam wiring_t III_BWD = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
  localparam wiring_t GAMMA_FWD = '{
    5'd5, 5'd18, 5'd14, 5'd10, 5'd0, 5'd13, 5'd20, 5'd4, 5'd17, 5'd7, 5'd12, 5'd1, 5'd19,
    5'd8, 5'd24, 5'd2, 5'd22, 5'd11, 5'd16, 5'd15, 5'd25, 5'd23, 5'd21, 5'd6, 5'd9, 5'd3};
  localparam wiring_t GAMMA_BWD = '{
    5'd4, 5'd11, 5'd15, 5'd25, 5'd7, 5'd0, 5'd23, 5'd9, 5'd13, 5'd24, 5'd3, 5'd17, 5'd10,
    5'd5, 5'd2, 5'd19, 5'd18, 5'd8, 5'd1, 5'd12, 5'd6, 5'd22, 5'd16, 5'd21, 5'd14, 5'd20};
  localparam wiring_t REFL = '{
    5'd5, 5'd21, 5'd15, 5'd9, 5'd8, 5'd0, 5'd14, 5'd24, 5'd4, 5'd3, 5'd17, 5'd25, 5'd23,
    5'd22, 5'd6, 5'd2, 5'd19, 5'd10, 5'd20, 5'd16, 5'd18, 5'd1, 5'd13, 5'd12, 5'd7, 5'd11};

  // letter plus rotor positions, carried from the stepper through every pass
  typedef struct packed {
    letter_t x;
    letter_t r;
    letter_t m;
    letter_t l;
  } enig_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } enig_qstat_t;

  // both operands below 26
  function automatic letter_t mod_add(letter_t a, letter_t b);
    letter_ext_t s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ALPHA_X) begin
      s = s - ALPHA_X;
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t mod_sub(letter_t a, letter_t b);
    letter_ext_t s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + ALPHA_X - {1'b0, b};
    end
    return s[LETTER_W-1:0];
  endfunction

  // one trip through a rotor or the reflector, with position offset
  function automatic enig_item_t enig_pass(logic [2:0] code, enig_item_t it);
    enig_item_t o;
    letter_t pos;
    letter_t e;
    letter_t w;
    o = it;
    case (code)
      PASS_BETA_FWD, PASS_BETA_BWD: pos = it.r;
      PASS_III_FWD, PASS_III_BWD: pos = it.m;
      PASS_GAMMA_FWD, PASS_GAMMA_BWD: pos = it.l;
      default: pos = '0;
    endcase
    e = mod_add(it.x, pos);
    case (code)
      PASS_BETA_FWD: w = BETA_FWD[e];
      PASS_III_FWD: w = III_FWD[e];
      PASS_GAMMA_FWD: w = GAMMA_FWD[e];
      PASS_REFL: w = REFL[e];
      PASS_GAMMA_BWD: w = GAMMA_BWD[e];
      PASS_III_BWD: w = III_BWD[e];
      PASS_BETA_BWD: w = BETA_BWD[e];
      default: w = e;
    endcase
    o.x = mod_sub(w, pos);
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/enig_front.sv
// Front end: start registers, rotor stepping and transaction intake.
`timescale 1ns / 1ps
`default_nettype none

module enig_front
  import enig_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LETTER_W-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LETTER_W-1:0]  in_plain_letter,
  input  wire logic                 q_full,
  output logic                      push,
  output enig_item_t                push_item
);

  letter_t right_start_r, middle_start_r, left_start_r;
  letter_t right_start_nxt, middle_start_nxt, left_start_nxt;
  letter_t right_pos_r, middle_pos_r, left_pos_r;
  letter_t right_pos_nxt, middle_pos_nxt, left_pos_nxt;

  letter_ext_t r_sum, m_sum, l_sum, x_ext;
  logic        carry_m, carry_l, reload;
  letter_t     r_step, m_step, l_step, x_mod;

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    r_sum   = {1'b0, right_pos_r} + RIGHT_STEP_X;
    carry_m = (r_sum >= ALPHA_X);
    r_step  = carry_m ? 5'(r_sum - ALPHA_X) : r_sum[LETTER_W-1:0];
    m_sum   = {1'b0, middle_pos_r} + {5'd0, carry_m};
    carry_l = (m_sum >= ALPHA_X);
    m_step  = carry_l ? 5'(m_sum - ALPHA_X) : m_sum[LETTER_W-1:0];
    l_sum   = {1'b0, left_pos_r} + {5'd0, carry_l};
    l_step  = (l_sum >= ALPHA_X) ? 5'(l_sum - ALPHA_X) : l_sum[LETTER_W-1:0];
    x_ext   = {1'b0, in_plain_letter};
    x_mod   = (x_ext >= ALPHA_X) ? 5'(x_ext - ALPHA_X) : in_plain_letter;
  end

  assign push_item = '{x: x_mod, r: r_step, m: m_step, l: l_step};

  always_comb begin
    right_start_nxt  = right_start_r;
    middle_start_nxt = middle_start_r;
    left_start_nxt   = left_start_r;
    right_pos_nxt    = right_pos_r;
    middle_pos_nxt   = middle_pos_r;
    left_pos_nxt     = left_pos_r;
    reload           = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RIGHT_START: begin
          right_start_nxt = cfg_data;
          reload = 1'b1;
        end
        CFG_MIDDLE_START: begin
          middle_start_nxt = cfg_data;
          reload = 1'b1;
        end
        CFG_LEFT_START: begin
          left_start_nxt = cfg_data;
          reload = 1'b1;
        end
        default: reload = 1'b0;
      endcase
      if (reload) begin
        right_pos_nxt  = right_start_nxt;
        middle_pos_nxt = middle_start_nxt;
        left_pos_nxt   = left_start_nxt;
      end
    end else if (push) begin
      right_pos_nxt  = r_step;
      middle_pos_nxt = m_step;
      left_pos_nxt   = l_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_start_r  <= '0;
      middle_start_r <= '0;
      left_start_r   <= '0;
      right_pos_r    <= '0;
      middle_pos_r   <= '0;
      left_pos_r     <= '0;
    end else begin
      right_start_r  <= right_start_nxt;
      middle_start_r <= middle_start_nxt;
      left_start_r   <= left_start_nxt;
      right_pos_r    <= right_pos_nxt;
      middle_pos_r   <= middle_pos_nxt;
      left_pos_r     <= left_pos_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/enig_queue.sv
// Small FIFO between the stepping front end and the cipher pipeline.
`timescale 1ns / 1ps
`default_nettype none

module enig_queue
  import enig_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  enig_item_t       push_item,
  input  wire logic        pop,
  output enig_item_t       head,
  output enig_qstat_t      stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  enig_item_t      store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign head       = store_r[rd_ptr_r];
  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10: count_nxt = count_r + 1'b1;
      2'b01: count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/enig_back.sv
// Cipher pipeline: one rotor or reflector pass per stage, last stage drives the output.
`timescale 1ns / 1ps
`default_nettype none

module enig_back
  import enig_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  enig_item_t               q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [LETTER_W-1:0]      out_cipher_letter
);

  logic [NUM_PASS-1:0] vld_r;
  enig_item_t          data_r [NUM_PASS];
  logic [NUM_PASS:0]   rdy;
  logic [NUM_PASS-1:0] stg_in_vld;
  enig_item_t          stg_in [NUM_PASS];

  always_comb begin
    rdy[NUM_PASS] = !out_stall;
    for (int i = NUM_PASS - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    stg_in_vld[0] = q_valid;
    stg_in[0]     = q_head;
    for (int i = 1; i < NUM_PASS; i++) begin
      stg_in_vld[i] = vld_r[i-1];
      stg_in[i]     = data_r[i-1];
    end
  end

  assign q_pop             = q_valid && rdy[0];
  assign out_valid         = vld_r[NUM_PASS-1];
  assign out_cipher_letter = data_r[NUM_PASS-1].x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NUM_PASS; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= stg_in_vld[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PASS; i++) begin
      if (rdy[i] && stg_in_vld[i]) begin
        data_r[i] <= enig_pass(3'(i), stg_in[i]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/three_rotor_enigma_cipher.sv
// Top level of the three-rotor letter cipher.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_plain_letter[4:0]
//   out      output     out_valid/out_stall  out_cipher_letter[4:0]
//   cfg      input      cfg_we               cfg_index[1:0], cfg_data[4:0]
//
// One transaction per cycle sustained while out_stall is low. An accepted transaction
// is written to the queue at the accept edge, then goes through seven pass stages, the
// last being the output register. Rotor stepping is a registered front-end update.
// Reset (synchronous, active low) clears start registers, positions, queue and pipeline.
// in_stall rises only when the queue is full; out_stall freezes the pass pipeline.
`timescale 1ns / 1ps
`default_nettype none

module three_rotor_enigma_cipher
  import enig_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LETTER_W-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LETTER_W-1:0]  in_plain_letter,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [LETTER_W-1:0]       out_cipher_letter
);

  logic        push, pop;
  enig_item_t  push_item, q_head;
  enig_qstat_t q_stat;

  enig_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_plain_letter (in_plain_letter),
    .q_full          (q_stat.full),
    .push            (push),
    .push_item       (push_item)
  );

  enig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  enig_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (!q_stat.empty),
    .q_head            (q_head),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter)
  );

`ifndef ASSERT_OFF
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cipher_letter < 5'd26))
    else $error("cipher letter out of range");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && q_stat.empty))
    else $error("pipeline or queue not cleared by reset");
`endif

endmodule

`default_nettype wire

FILE: verif/three_rotor_enigma_cipher_test.sv
// Self-checking testbench for the three-rotor letter cipher: random traffic, scoreboard.
`timescale 1ns / 1ps

module three_rotor_enigma_cipher_test;
  import enig_pkg::*;

  class rotor_cipher_scoreboard;
    localparam int unsigned LETTERS = 26;
    localparam int unsigned RIGHT_ADVANCE = 4;

    string beta_wiring = "LEYJVCNIXWPBQMDRTAKZGFUHOS";
    string iii_wiring = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    string gamma_wiring = "FSOKANUERHMBTIYCWLQPZXVGJD";
    string refl_wiring = "FVPJIAOYEDRZXWGCTKUQSBNMHL";

    int unsigned right_start, middle_start, left_start;
    int unsigned right_pos, middle_pos, left_pos;
    letter_t expected_cipher[$];
    int unsigned mismatches;

    function int unsigned wire_map(string w, int unsigned e, bit back);
      int unsigned i;
      if (!back) begin
        return int'(w.getc(e)) - int'("A");
      end
      for (i = 0; i < LETTERS; i++) begin
        if (int'(w.getc(i)) - int'("A") == e) begin
          return i;
        end
      end
      return 0;
    endfunction

    function int unsigned through(string w, int unsigned x, int unsigned pos, bit back);
      int unsigned o;
      o = wire_map(w, (x + pos) % LETTERS, back);
      return (o + LETTERS - (pos % LETTERS)) % LETTERS;
    endfunction

    function void write_start(logic [CFG_IDX_W-1:0] idx, letter_t val);
      case (idx)
        CFG_RIGHT_START: right_start = val;
        CFG_MIDDLE_START: middle_start = val;
        CFG_LEFT_START: left_start = val;
        default: return;
      endcase
      right_pos = right_start;
      middle_pos = middle_start;
      left_pos = left_start;
    endfunction

    function void note_plain(letter_t plain);
      int unsigned x;
      right_pos += RIGHT_ADVANCE;
      if (right_pos >= LETTERS) begin
        middle_pos += 1;
        right_pos %= LETTERS;
      end
      if (middle_pos >= LETTERS) begin
        left_pos += 1;
        middle_pos %= LETTERS;
      end
      left_pos %= LETTERS;
      x = plain % LETTERS;
      x = through(beta_wiring, x, right_pos, 1'b0);
      x = through(iii_wiring, x, middle_pos, 1'b0);
      x = through(gamma_wiring, x, left_pos, 1'b0);
      x = wire_map(refl_wiring, x, 1'b0);
      x = through(gamma_wiring, x, left_pos, 1'b1);
      x = through(iii_wiring, x, middle_pos, 1'b1);
      x = through(beta_wiring, x, right_pos, 1'b1);
      expected_cipher.push_back(letter_t'(x));
    endfunction

    function void check_cipher(letter_t got);
      letter_t exp_letter;
      if (expected_cipher.size() == 0) begin
        $display("%0t: unexpected cipher_letter, expected none, actual %0d", $time, got);
        mismatches++;
        return;
      end
      exp_letter = expected_cipher.pop_front();
      if (got !== exp_letter) begin
        $display("%0t: cipher_letter mismatch, expected %0d, actual %0d",
                 $time, exp_letter, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LETTER_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LETTER_W-1:0] in_plain_letter = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LETTER_W-1:0] out_cipher_letter;

  bit idle_on = 1'b1;
  rotor_cipher_scoreboard sb = new();

  three_rotor_enigma_cipher u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_plain_letter(in_plain_letter),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cipher_letter(out_cipher_letter)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_cipher(out_cipher_letter);
      end
      if (in_valid && !in_stall) begin
        sb.note_plain(in_plain_letter);
      end
      if (cfg_we) begin
        sb.write_start(cfg_index, cfg_data);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // called right after a falling edge, returns right after one
  task automatic send_letter(input letter_t plain);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_plain_letter = plain;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_cipher.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input letter_t val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic letter_t pick_start();
    case ($urandom_range(0, 9))
      0: return letter_t'(0);
      1: return letter_t'(25);
      2: return letter_t'($urandom_range(26, 31));
      default: return letter_t'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic letter_t pick_letter();
    if ($urandom_range(0, 7) == 0) begin
      return letter_t'($urandom_range(26, 31));
    end
    return letter_t'($urandom_range(0, 25));
  endfunction

  initial begin
    int unsigned phase;
    int unsigned k;
    int unsigned n_writes;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset positions, letter extremes and out-of-range letters
    send_letter(5'd0);
    send_letter(5'd25);
    send_letter(5'd26);
    send_letter(5'd31);
    send_letter(5'd1);
    send_letter(5'd30);
    send_letter(5'd16);
    send_letter(5'd15);
    drain();

    // unmapped index must not reload positions
    write_reg(2'd3, 5'd17);
    send_letter(5'd7);
    send_letter(5'd19);
    drain();

    // starts above 25 on every rotor
    write_reg(CFG_RIGHT_START, 5'd31);
    write_reg(CFG_MIDDLE_START, 5'd31);
    write_reg(CFG_LEFT_START, 5'd31);
    for (k = 0; k < 6; k++) send_letter(pick_letter());
    drain();

    write_reg(CFG_RIGHT_START, 5'd25);
    write_reg(CFG_MIDDLE_START, 5'd25);
    write_reg(CFG_LEFT_START, 5'd25);
    for (k = 0; k < 5; k++) send_letter(pick_letter());
    drain();

    for (phase = 0; phase < 12; phase++) begin
      if (phase >= 10) idle_on = 1'b0;
      n_writes = $urandom_range(1, 4);
      for (k = 0; k < n_writes; k++) begin
        write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_start());
      end
      for (k = 0; k < 95; k++) send_letter(pick_letter());
      drain();
    end

    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_cipher.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
